// ----- rtl/quantized_to_float_dequantizer_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the dequantizer core RTL.
// ---------------------------------------------------------------------------
`ifndef QUANTIZED_TO_FLOAT_DEQUANTIZER_CORE_MACROS_SVH
`define QUANTIZED_TO_FLOAT_DEQUANTIZER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define QD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define QD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/qdeq_pkg.sv -----
// ---------------------------------------------------------------------------
// qdeq_pkg
// Types, register indexes and element kind codes of the dequantizer.
// ---------------------------------------------------------------------------
package qdeq_pkg;

  typedef enum logic [3:0] {
    KIND_UFIX8  = 4'd0,
    KIND_UFIX16 = 4'd1,
    KIND_U8     = 4'd2,
    KIND_U16    = 4'd3,
    KIND_S8     = 4'd4,
    KIND_S16    = 4'd5,
    KIND_S32    = 4'd6,
    KIND_U32    = 4'd7,
    KIND_F32    = 4'd8
  } kind_e;

  localparam logic [1:0] RegDataKind    = 2'd0;
  localparam logic [1:0] RegQuantOffset = 2'd1;
  localparam logic [1:0] RegQuantScale  = 2'd2;

  localparam logic [31:0] ScaleReset  = 32'h3F80_0000;
  localparam logic [31:0] DefaultNan  = 32'h7FC0_0000;
  localparam logic [31:0] PosInf      = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] raw_element;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        ends_tensor;
  } out_item_t;

  // Work passed from the convert stage to the scale stage.
  typedef struct packed {
    logic        need_mul;  // fixed-point kind: multiply by scale
    logic [31:0] conv;      // converted integer as binary32, or the raw bits for KIND_F32
    logic        last;
  } stage_t;

  // Position of the leading one of a 48-bit value.
  function automatic logic [5:0] lead_one48(input logic [47:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Convert a signed 34-bit integer to binary32, nearest even.
  function automatic logic [31:0] int_to_f32(input logic signed [33:0] v);
    logic        sgn;
    logic [33:0] mag;
    logic [5:0]  p;
    logic [33:0] norm;
    logic [23:0] man;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic [7:0]  ex;
    sgn  = v[33];
    mag  = sgn ? 34'(-v) : 34'(v);
    p    = lead_one48({14'd0, mag});
    norm = mag << (6'd33 - p);
    man  = norm[33:10];
    g    = norm[9];
    st   = |norm[8:0];
    rnd  = {1'b0, man} + 25'(g & (st | man[0]));
    ex   = 8'(p) + 8'd127;
    if (mag == 34'd0) return 32'd0;
    if (rnd[24]) ex = ex + 8'd1;
    return {sgn, ex, rnd[24] ? rnd[23:1] : rnd[22:0]};
  endfunction

endpackage

// ----- rtl/quantized_to_float_dequantizer_core.sv -----
// ---------------------------------------------------------------------------
// quantized_to_float_dequantizer_core
// Streams raw tensor elements to binary32 values, one per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// An accepted element passes the convert stage register, then the result register, before it is valid.
// Throughput: one transaction per cycle through two register stages.
// The stages advance together unless a valid result is stalled at the output.
// Reset clears the valid bits and loads the configuration and convert stage registers with their defaults.
module quantized_to_float_dequantizer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qdeq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qdeq_pkg::out_item_t out_item_o
);
  import qdeq_pkg::*;
  `include "quantized_to_float_dequantizer_core_macros.svh"

  logic [3:0]  data_kind_q;
  logic [31:0] quant_offset_q, quant_scale_q;
  logic        v1_q, v2_q, adv;
  stage_t      stage;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_kind_q    <= KIND_UFIX8;
      quant_offset_q <= 32'd0;
      quant_scale_q  <= ScaleReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegDataKind)    data_kind_q    <= cfg_data_i[3:0];
      if (cfg_index_i == RegQuantOffset) quant_offset_q <= cfg_data_i;
      if (cfg_index_i == RegQuantScale)  quant_scale_q  <= cfg_data_i;
    end
  end

  // The whole pipe moves unless a result is held.
  assign adv        = !(v2_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  qdeq_convert u_convert (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .data_kind_i    (data_kind_q),
    .quant_offset_i (quant_offset_q),
    .item_i         (in_item_i),
    .stage_o        (stage)
  );

  qdeq_scale u_scale (
    .clk_i         (clk_i),
    .en_i          (adv && v1_q),
    .quant_scale_i (quant_scale_q),
    .stage_i       (stage),
    .item_o        (out_item_o)
  );

  assign out_valid_o = v2_q;

  `QD_ASSERT(a_hold, clk_i, rst_ni, (v2_q && out_stall_i) |=> v2_q, "result lost under stall")
  `QD_ASSERT(a_stall, clk_i, rst_ni, in_stall_o |-> (v2_q && out_stall_i), "needless input stall")
  `QD_ASSERT(a_flow, clk_i, rst_ni, (v1_q && adv) |=> v2_q, "item dropped between stages")
endmodule

// ----- rtl/qdeq_convert.sv -----
// ---------------------------------------------------------------------------
// qdeq_convert
// Input register stage: forms the integer per kind and converts it to float.
// ---------------------------------------------------------------------------
module qdeq_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [3:0]        data_kind_i,
  input  logic [31:0]       quant_offset_i,
  input  qdeq_pkg::in_item_t item_i,
  output qdeq_pkg::stage_t  stage_o
);
  import qdeq_pkg::*;

  logic [31:0]        raw;
  logic signed [33:0] ival;
  stage_t             stage_d, stage_q;

  assign raw = item_i.raw_element;

  // Select the integer operand for this kind.
  always_comb begin
    ival            = 34'sd0;
    stage_d.need_mul = 1'b0;
    unique case (data_kind_i)
      KIND_UFIX8: begin
        ival = $signed({{2{quant_offset_i[31]}}, quant_offset_i}) + $signed({26'd0, raw[7:0]});
        stage_d.need_mul = 1'b1;
      end
      KIND_UFIX16: begin
        ival = $signed({{2{quant_offset_i[31]}}, quant_offset_i}) + $signed({18'd0, raw[15:0]});
        stage_d.need_mul = 1'b1;
      end
      KIND_U8:  ival = $signed({26'd0, raw[7:0]});
      KIND_U16: ival = $signed({18'd0, raw[15:0]});
      KIND_S8:  ival = $signed({{26{raw[7]}}, raw[7:0]});
      KIND_S16: ival = $signed({{18{raw[15]}}, raw[15:0]});
      KIND_S32: ival = $signed({{2{raw[31]}}, raw});
      KIND_U32: ival = $signed({2'd0, raw});
      default:  ival = 34'sd0;
    endcase
    stage_d.conv = (data_kind_i == KIND_F32) ? raw : int_to_f32(ival);
    stage_d.last = item_i.is_last;
  end

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

// ----- rtl/qdeq_scale.sv -----
// ---------------------------------------------------------------------------
// qdeq_scale
// Result register stage: binary32 multiply by the scale, nearest even, for fixed-point kinds only.
// ---------------------------------------------------------------------------
module qdeq_scale (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        quant_scale_i,
  input  qdeq_pkg::stage_t   stage_i,
  output qdeq_pkg::out_item_t item_o
);
  import qdeq_pkg::*;

  logic [31:0] a, b;
  logic        sgn, za, zb, na, nb, ia, ib;
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic [5:0]  p;
  logic signed [10:0] e, sh, sub;
  logic [47:0] rem, half, mask;
  logic [47:0] m2;
  logic [47:0] m2r;
  logic signed [12:0] bits_e;
  logic [33:0] bits;
  logic [31:0] mul_res;
  out_item_t   item_d, item_q;

  assign a = stage_i.conv;
  assign b = quant_scale_i;

  // Multiply with round and pack, including subnormal results.
  always_comb begin
    sgn = a[31] ^ b[31];
    za  = (a[30:0] == 31'd0);
    zb  = (b[30:0] == 31'd0);
    na  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia  = (a[30:23] == 8'hFF);
    ib  = (b[30:23] == 8'hFF);
    ma  = {(a[30:23] != 8'd0), a[22:0]};
    mb  = {(b[30:23] != 8'd0), b[22:0]};
    prod = ma * mb;
    p    = lead_one48(prod);
    e    = 11'($signed({3'd0, (a[30:23] != 8'd0) ? a[30:23] : 8'd1}))
         + 11'($signed({3'd0, (b[30:23] != 8'd0) ? b[30:23] : 8'd1})) - 11'sd300;
    sh   = $signed({5'd0, p}) - 11'sd23;
    sub  = -11'sd149 - e;
    if (sub > sh) sh = sub;
    m2   = 48'd0;
    rem  = 48'd0;
    half = 48'd0;
    mask = 48'd0;
    if (sh <= 0) begin
      m2 = prod << 6'(-sh);
    end else if (sh < 48) begin
      mask = (48'd1 << 6'(sh)) - 48'd1;
      rem  = prod & mask;
      half = 48'd1 << 6'(sh - 11'sd1);
      m2   = prod >> 6'(sh);
    end
    m2r    = m2 + 48'((rem > half) || ((rem == half) && (sh > 0) && (sh < 48) && m2[0]));
    bits_e = 13'(sh) + 13'(e) + 13'sd149;
    bits   = 34'($signed({bits_e, 23'd0})) + 34'(m2r);
    if (bits_e < 0 || $signed(bits) >= $signed({2'b00, PosInf})) bits = {2'b00, PosInf};
    if (na)                mul_res = a | 32'h0040_0000;
    else if (nb)           mul_res = b | 32'h0040_0000;
    else if (ia || ib)     mul_res = (za || zb) ? DefaultNan : {sgn, PosInf[30:0]};
    else if (za || zb)     mul_res = {sgn, 31'd0};
    else                   mul_res = {sgn, bits[30:0]};
    item_d.value_bits  = stage_i.need_mul ? mul_res : a;
    item_d.ends_tensor = stage_i.last;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (en_i) item_q <= item_d;
  end

  assign item_o = item_q;
endmodule
